### sv/assert_macros.svh
// assertion macros shared by the lsb-first bit unpacker modules
// no dependencies; the including module must have clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define LBU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define LBU_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LBU_ASSERT(lbl, prop, msg)
`define LBU_NEVER(lbl, cond, msg)
`endif
`endif

### sv/lbu_pkg.sv
// types and constants for the lsb-first bit unpacker
// no dependencies; used by the front end, queue, back end and top level
package lbu_pkg;

    // fixed field widths of a request and a result
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int ALIGN_W     = 3;
    localparam int VALUE_W     = 64;
    localparam int AVAIL_W     = 9;
    // remainder of count by the word length, word length at most 64
    localparam int REM_W       = 6;
    // width of the rounded align position (offset below 64 plus step up to 128)
    localparam int ALIGN_POS_W = 8;

    // command queue between front and back end
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        FN_PUSH  = 2'd0,
        FN_READ  = 2'd1,
        FN_SKIP  = 2'd2,
        FN_ALIGN = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EOF   = 2'd1,
        ST_LIMIT = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // classified request as it travels through the queue
    typedef struct packed {
        func_t               func;
        logic [WORD_W-1:0]   word;
        logic [COUNT_W-1:0]  count;
        logic [ALIGN_W-1:0]  align_log2;
        logic [REM_W-1:0]    count_rem;
    } cmd_t;

endpackage

### sv/lbu_cmd_if.sv
// request channel of the lsb-first bit unpacker: valid/ready plus request fields
// no dependencies
interface lbu_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] word;
    logic [15:0] count;
    logic [2:0]  align_log2;

    modport source (output valid, output func, output word, output count,
                    output align_log2, input ready);
    modport sink   (input valid, input func, input word, input count,
                    input align_log2, output ready);
endinterface

### sv/lbu_res_if.sv
// result channel of the lsb-first bit unpacker: valid/ready plus result fields
// no dependencies
interface lbu_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  status;
    logic        fail;
    logic [8:0]  bits_available;

    modport source (output valid, output value, output status, output fail,
                    output bits_available, input ready);
    modport sink   (input valid, input value, input status, input fail,
                    input bits_available, output ready);
endinterface

### sv/lsb_first_bit_unpacker.sv
// LSB-first bit unpacker: stream words are pushed into a buffer of BUFFER_WORDS words of
// WORD_BITS bits, and read, skip and align requests take bits from it with bit 0 of each
// word first; every request gives one result. The unit takes one request per clock while
// the queue has room; a request passes the front stage register, a queue entry and the
// result register in that order, and the rate rests on the back end's combinational
// shift of the whole bit buffer, which both extracts a read and drops consumed bits.
// A four-entry queue between the decode stage and the back end keeps requests flowing
// while a result waits.
// depends on lbu_pkg, lbu_cmd_if, lbu_res_if, lbu_front, lbu_queue and lbu_back
module lsb_first_bit_unpacker #(
    parameter int WORD_BITS    = 32,
    parameter int BUFFER_WORDS = 8,
    parameter int READ_BITS    = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    lbu_cmd_if.sink   cmd,
    lbu_res_if.source res
);
    import lbu_pkg::*;

    cmd_t q_in;
    cmd_t q_out;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // request decode and count remainder
    lbu_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // queue between the two sides
    lbu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // execution and result register
    lbu_back #(
        .WORD_BITS    (WORD_BITS),
        .BUFFER_WORDS (BUFFER_WORDS),
        .READ_BITS    (READ_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

### sv/lbu_front.sv
// front end: accepts requests, decodes them and works out count modulo the word length
// depends on lbu_pkg and lbu_cmd_if
module lbu_front #(
    parameter int WORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    lbu_cmd_if.sink       cmd,
    input  logic          q_full,
    output logic          q_push,
    output lbu_pkg::cmd_t q_data
);
    import lbu_pkg::*;

    // reciprocal of the word length, exact floor quotient for any 16-bit count
    localparam int LOG_W  = $clog2(WORD_BITS);
    localparam int SHIFT  = COUNT_W + LOG_W;
    localparam int PROD_W = COUNT_W + SHIFT;
    localparam longint unsigned RECIP =
        ((longint'(1) << SHIFT) + WORD_BITS - 1) / WORD_BITS;

    logic               a_valid_reg;
    cmd_t               a_item_reg;
    logic [COUNT_W-1:0] a_quot_reg;
    logic               advance;
    logic               accept;
    logic [PROD_W-1:0]  prod;
    logic [COUNT_W-1:0] rem_full;

    // stage moves on when empty or when its request enters the queue
    assign advance   = !a_valid_reg || !q_full;
    assign cmd.ready = advance;
    assign accept    = cmd.valid && advance;
    assign q_push    = a_valid_reg && !q_full;

    // quotient estimate by multiply with the reciprocal
    assign prod = PROD_W'(cmd.count) * PROD_W'(RECIP);

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= accept;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg.func       <= func_t'(cmd.func);
            a_item_reg.word       <= cmd.word;
            a_item_reg.count      <= cmd.count;
            a_item_reg.align_log2 <= cmd.align_log2;
            a_item_reg.count_rem  <= '0;
            a_quot_reg            <= prod[PROD_W-1:SHIFT];
        end
    end

    // remainder from the registered quotient
    assign rem_full = a_item_reg.count - a_quot_reg * COUNT_W'(WORD_BITS);

    always_comb
    begin
        q_data           = a_item_reg;
        q_data.count_rem = REM_W'(rem_full);
    end

endmodule

### sv/lbu_queue.sv
// short request queue between the front end and the back end
// depends on lbu_pkg and assert_macros.svh
`include "assert_macros.svh"

module lbu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lbu_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output lbu_pkg::cmd_t pop_data,
    output logic          empty
);
    import lbu_pkg::*;

    cmd_t               entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   fill_reg;
    logic [Q_PTR_W:0]   fill_next;

    assign full     = (fill_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `LBU_NEVER(a_push_when_full, push && full, "request pushed into a full queue")
    `LBU_NEVER(a_pop_when_empty, pop && empty, "request popped from an empty queue")

endmodule

### sv/lbu_back.sv
// back end: bit buffer, position bookkeeping and result register
// depends on lbu_pkg, lbu_res_if and assert_macros.svh
`include "assert_macros.svh"

module lbu_back #(
    parameter int WORD_BITS    = 32,
    parameter int BUFFER_WORDS = 8,
    parameter int READ_BITS    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lbu_pkg::cmd_t q_data,
    input  logic          q_empty,
    output logic          q_pop,
    lbu_res_if.source     res
);
    import lbu_pkg::*;

    localparam int BUF_BITS = BUFFER_WORDS * WORD_BITS;
    localparam int AW       = $clog2(BUF_BITS + 1);
    localparam int OW       = $clog2(WORD_BITS);
    localparam int WIN_BITS = (BUF_BITS > VALUE_W) ? BUF_BITS : VALUE_W;
    localparam int CW       = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
    localparam int SW       = REM_W + 1;
    localparam logic [AW-1:0] FULL_LEVEL = AW'((BUFFER_WORDS - 1) * WORD_BITS);
    localparam logic [AW-1:0] WORD_LEN   = AW'(WORD_BITS);
    localparam logic [BUF_BITS-1:0] WORD_MASK = BUF_BITS'({WORD_BITS{1'b1}});

    // buffered bits, next unread bit always at bit 0
    logic [BUF_BITS-1:0]    bits_reg;
    logic [BUF_BITS-1:0]    bits_next;
    logic [AW-1:0]          avail_reg;
    logic [AW-1:0]          avail_next;
    logic [OW-1:0]          off_reg;
    logic [OW-1:0]          off_next;
    logic                   fail_reg;
    logic                   fail_next;
    logic                   res_valid_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [VALUE_W-1:0]     value_calc;
    status_t                status_reg;
    status_t                status_calc;
    logic [AVAIL_W-1:0]     bits_avail_reg;

    logic [WIN_BITS-1:0]    window;
    logic [BUF_BITS-1:0]    push_word;
    logic [VALUE_W-1:0]     read_mask;
    logic                   over_avail;
    logic                   over_limit;
    logic [SW-1:0]          rem_sum;
    logic [SW-1:0]          rem_wrap;
    logic [ALIGN_POS_W-1:0] step_m1;
    logic [ALIGN_POS_W-1:0] align_pos;
    logic                   consume;
    logic                   do_shift;
    logic [AW-1:0]          shift_amt;

    assign q_pop = !q_empty && (!res_valid_reg || res.ready);

    // request classification against the current fill
    assign over_avail = CW'(q_data.count) > CW'(avail_reg);
    assign over_limit = q_data.count > COUNT_W'(READ_BITS);
    assign window     = WIN_BITS'(bits_reg);
    assign push_word  = BUF_BITS'(WORD_BITS'(q_data.word));
    assign read_mask  = (q_data.count >= COUNT_W'(VALUE_W)) ? '1 :
                        ((VALUE_W'(1) << q_data.count) - VALUE_W'(1));

    // new offset inside the head word after consuming count bits
    assign rem_sum  = SW'(off_reg) + SW'(q_data.count_rem);
    assign rem_wrap = (rem_sum >= SW'(WORD_BITS)) ? rem_sum - SW'(WORD_BITS) : rem_sum;

    // offset rounded up to the alignment step
    assign step_m1   = (ALIGN_POS_W'(1) << q_data.align_log2) - ALIGN_POS_W'(1);
    assign align_pos = (ALIGN_POS_W'(off_reg) + step_m1) & ~step_m1;

    // command execution
    always_comb
    begin
        bits_next   = bits_reg;
        avail_next  = avail_reg;
        off_next    = off_reg;
        fail_next   = fail_reg;
        value_calc  = '0;
        status_calc = ST_OK;
        consume     = 1'b0;
        do_shift    = 1'b0;
        shift_amt   = '0;

        case (q_data.func)
            FN_PUSH:
            begin
                if (avail_reg > FULL_LEVEL)
                begin
                    status_calc = ST_FULL;
                end
                else
                begin
                    bits_next  = (bits_reg & ~(WORD_MASK << avail_reg))
                               | (push_word << avail_reg);
                    avail_next = avail_reg + WORD_LEN;
                end
            end
            FN_READ:
            begin
                if (over_limit)
                begin
                    status_calc = ST_LIMIT;
                end
                else if (over_avail)
                begin
                    status_calc = ST_EOF;
                    fail_next   = 1'b1;
                end
                else
                begin
                    value_calc = window[VALUE_W-1:0] & read_mask;
                    consume    = 1'b1;
                end
            end
            FN_SKIP:
            begin
                if (over_avail)
                begin
                    status_calc = ST_EOF;
                    fail_next   = 1'b1;
                end
                else
                begin
                    consume = 1'b1;
                end
            end
            FN_ALIGN:
            begin
                if (off_reg != '0)
                begin
                    do_shift = 1'b1;
                    if (align_pos >= ALIGN_POS_W'(WORD_BITS))
                    begin
                        // rest of the head word is dropped
                        shift_amt = WORD_LEN - AW'(off_reg);
                        off_next  = '0;
                    end
                    else
                    begin
                        shift_amt = AW'(align_pos) - AW'(off_reg);
                        off_next  = OW'(align_pos);
                    end
                end
            end
            default:
            begin
                status_calc = ST_OK;
            end
        endcase

        if (consume)
        begin
            do_shift  = 1'b1;
            shift_amt = q_data.count[AW-1:0];
            off_next  = OW'(rem_wrap);
        end

        if (do_shift)
        begin
            bits_next  = bits_reg >> shift_amt;
            avail_next = avail_reg - shift_amt;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg     <= '0;
            off_reg       <= '0;
            fail_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            avail_reg     <= avail_next;
            off_reg       <= off_next;
            fail_reg      <= fail_next;
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // bit buffer and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bits_reg       <= bits_next;
            value_reg      <= value_calc;
            status_reg     <= status_calc;
            bits_avail_reg <= AVAIL_W'(avail_next);
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.value          = value_reg;
    assign res.status         = status_reg;
    assign res.fail           = fail_reg;
    assign res.bits_available = bits_avail_reg;

    `LBU_ASSERT(a_off_in_word, off_reg < OW'(WORD_BITS - 1) || off_reg == OW'(WORD_BITS - 1), "bit offset past the word end")
    `LBU_ASSERT(a_off_needs_data, off_reg != '0 |-> avail_reg != '0, "offset set on an empty buffer")
    `LBU_ASSERT(a_avail_bound, avail_reg <= AW'(BUF_BITS), "more bits buffered than the store holds")

endmodule
